/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rate limiter rtl
// no dependencies; taken in by `include where a module checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/tbrl_pkg.sv */
// shared types and constants for the token bucket rate limiter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package tbrl_pkg;

  localparam int FP_W       = 16;
  localparam int TOK_W      = 32;
  localparam int REQ_W      = 32;
  localparam int PER_W      = 48;
  localparam int MS_W       = 63;
  localparam int LVL_OUT_W  = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int LEVEL_BITS_DEF = 48;

  localparam logic [FP_W-1:0]  RST_FILL_PERIOD = 16'd100;
  localparam logic [TOK_W-1:0] RST_TOKENS      = 32'd1024;
  localparam logic [TOK_W-1:0] RST_CAPACITY    = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_PERIOD = 2'd0,
    CFG_TOKENS      = 2'd1,
    CFG_CAPACITY    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    CMD_TICK    = 1'b0,
    CMD_CONSUME = 1'b1
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLAMP = 5'b00010,
    S_APPLY = 5'b00100,
    S_DIV   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  // sequencer to bucket
  typedef struct packed {
    logic clamp;
    logic apply;
    logic consume;
  } bkt_ctrl_t;

  // bucket to sequencer
  typedef struct packed {
    logic fits;
    logic granted;
  } bkt_stat_t;

  // serial divider to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hw/rtl/tbrl_bucket.sv */
// bucket level register with clamp, refill and consume arithmetic
// depends on tbrl_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbrl_bucket #(
  parameter int LEVEL_BITS = tbrl_pkg::LEVEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tbrl_pkg::bkt_ctrl_t           ctrl,
  input  logic [tbrl_pkg::REQ_W-1:0]    req,
  input  logic [tbrl_pkg::TOK_W-1:0]    tokens,
  input  logic [tbrl_pkg::TOK_W-1:0]    capacity,
  output tbrl_pkg::bkt_stat_t           stat,
  output logic signed [LEVEL_BITS-1:0]  level,
  output logic [LEVEL_BITS-1:0]         deficit_m1
);

  localparam int L = LEVEL_BITS;

  logic signed [L-1:0] level_r, level_nxt;
  logic signed [L-1:0] cap_ext, tok_ext, clamped, sum, sum_cl, level_min;
  logic signed [L:0]   diff;
  logic                fits, underflow;
  logic                granted_r;

  assign cap_ext   = $signed({{(L-tbrl_pkg::TOK_W){1'b0}}, capacity});
  assign tok_ext   = $signed({{(L-tbrl_pkg::TOK_W){1'b0}}, tokens});
  assign level_min = $signed({1'b1, {(L-1){1'b0}}});

  assign clamped = (level_r > cap_ext) ? cap_ext : level_r;
  // level is already clamped here, so the sum stays well inside the range
  assign sum     = level_r + tok_ext;
  assign sum_cl  = (sum > cap_ext) ? cap_ext : sum;

  assign diff      = $signed({level_r[L-1], level_r})
                   - $signed({{(L+1-tbrl_pkg::REQ_W){1'b0}}, req});
  assign fits      = !diff[L];
  assign underflow = diff[L] & ~diff[L-1];

  // req - level - 1 is the bitwise inverse of level - req
  assign deficit_m1 = ~diff[L-1:0];

  always_comb begin
    level_nxt = level_r;
    if (ctrl.clamp) begin
      level_nxt = clamped;
    end else if (ctrl.apply) begin
      if (!ctrl.consume) begin
        level_nxt = sum_cl;
      end else if (underflow) begin
        level_nxt = level_min;
      end else begin
        level_nxt = $signed(diff[L-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= $signed({{(L-tbrl_pkg::TOK_W){1'b0}}, tbrl_pkg::RST_CAPACITY});
      granted_r <= 1'b1;
    end else begin
      level_r <= level_nxt;
      if (ctrl.apply) begin
        granted_r <= !ctrl.consume || fits;
      end
    end
  end

  assign level        = level_r;
  assign stat.fits    = fits;
  assign stat.granted = granted_r;

  `ASSERT_NEXT(a_clamp_bound, clk, rst_n, ctrl.clamp, level_r <= cap_ext,
               "level above capacity after clamp")
  `ASSERT_NEXT(a_grant_nonneg, clk, rst_n, ctrl.apply && ctrl.consume && fits,
               !level_r[L-1], "granted consume left a negative level")

endmodule

/* hw/rtl/tbrl_sdiv.sv */
// bit-serial restoring divider, one quotient bit per cycle, with the
// quotient times the fill period built alongside; depends on tbrl_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbrl_sdiv #(
  parameter int LEVEL_BITS = tbrl_pkg::LEVEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [LEVEL_BITS-1:0]       dividend,
  input  logic [tbrl_pkg::TOK_W-1:0]  tokens,
  input  logic [tbrl_pkg::FP_W-1:0]   fill_ms,
  output tbrl_pkg::div_stat_t         stat,
  output logic [LEVEL_BITS-1:0]       quot,
  output logic [LEVEL_BITS+tbrl_pkg::FP_W-1:0] prod
);

  localparam int L     = LEVEL_BITS;
  localparam int TW    = tbrl_pkg::TOK_W;
  localparam int AW    = LEVEL_BITS + tbrl_pkg::FP_W;
  localparam int CNT_W = $clog2(LEVEL_BITS + 1);

  logic [L-1:0]     quo_r;
  logic [TW-1:0]    rem_r;
  logic [AW-1:0]    acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;

  logic [TW:0]      shifted, diff;
  logic             ge;

  // dividend bits leave at the top while quotient bits enter at the bottom
  assign shifted = {rem_r, quo_r[L-1]};
  assign ge      = shifted >= {1'b0, tokens};
  assign diff    = shifted - {1'b0, tokens};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(L);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      busy_r <= (cnt_r != CNT_W'(1));
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      acc_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[L-2:0], ge};
      rem_r <= ge ? diff[TW-1:0] : shifted[TW-1:0];
      // horner form: product follows the quotient msb first
      acc_r <= {acc_r[AW-2:0], 1'b0} + (ge ? AW'(fill_ms) : AW'(0));
    end
  end

  assign quot      = quo_r;
  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_r && !done_r,
               "divider did not start")
  `ASSERT_SAME(a_busy_count, clk, rst_n, busy_r, cnt_r != '0,
               "divider busy with an empty count")

endmodule

/* hw/rtl/token_bucket_rate_limiter.sv */
// token bucket rate limiter that allows debt: top level with sequencer,
// config registers and result register; depends on tbrl_pkg, tbrl_bucket, tbrl_sdiv
//
// usage: the input channel carries one item per beat, command (0 = one refill
// period elapsed, 1 = consume request_bytes tokens). each item yields exactly one
// result beat on the output channel: granted, wait_periods, wait_ms, token_level.
// the config channel writes fill_period_ms (index 0), tokens_per_period (1) and
// capacity (2); other indexes are dropped. write only while no item is in flight.
// sequence: a tick or a granted consume passes the clamp, apply and fin states, and
// the next item can be taken once the sequencer is back in idle. a consume that
// runs into debt also passes through the serial divider between apply and fin,
// one quotient bit per cycle, and moves on to fin on the divider's done flag.
// one item is in work at a time; in_stall stays high from accept until the result
// is written to the output register, so the next item can be taken while that
// result still waits.
// a result waits in its register while out_stall is high; a finished item waits
// for that register to free up before the sequencer goes back to idle.
// reset (synchronous, active low) loads the register defaults (100 ms, 1024 tokens,
// capacity 65536), fills the bucket to 65536 and clears both channels.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module token_bucket_rate_limiter #(
  parameter int LEVEL_BITS = tbrl_pkg::LEVEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_command,
  input  logic [tbrl_pkg::REQ_W-1:0]            in_request_bytes,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_granted,
  output logic [tbrl_pkg::PER_W-1:0]            out_wait_periods,
  output logic [tbrl_pkg::MS_W-1:0]             out_wait_ms,
  output logic signed [tbrl_pkg::LVL_OUT_W-1:0] out_token_level,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tbrl_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int L   = LEVEL_BITS;
  localparam int AW  = LEVEL_BITS + tbrl_pkg::FP_W;
  localparam int PW  = (L + 1 > tbrl_pkg::PER_W + 1) ? L + 1 : tbrl_pkg::PER_W + 1;
  localparam int WW  = (AW + 1 > tbrl_pkg::MS_W + 1) ? AW + 1 : tbrl_pkg::MS_W + 1;
  localparam int LW  = (L > tbrl_pkg::LVL_OUT_W) ? L : tbrl_pkg::LVL_OUT_W;
  localparam int OW  = tbrl_pkg::LVL_OUT_W;

  tbrl_pkg::state_t state_r, state_nxt;

  logic [tbrl_pkg::FP_W-1:0]  fill_ms_r;
  logic [tbrl_pkg::TOK_W-1:0] tokens_r;
  logic [tbrl_pkg::TOK_W-1:0] capacity_r;

  logic                       cmd_r;
  logic [tbrl_pkg::REQ_W-1:0] req_r;

  logic                        out_valid_r;
  logic                        out_granted_r;
  logic [tbrl_pkg::PER_W-1:0]  out_periods_r;
  logic [tbrl_pkg::MS_W-1:0]   out_ms_r;
  logic signed [OW-1:0]        out_level_r;

  tbrl_pkg::bkt_ctrl_t bkt_ctrl;
  tbrl_pkg::bkt_stat_t bkt_stat;
  tbrl_pkg::div_stat_t div_stat;

  logic signed [L-1:0] level;
  logic [L-1:0]        deficit_m1;
  logic [L-1:0]        quot;
  logic [AW-1:0]       prod;
  logic                div_start;

  logic                in_take, out_free, out_load;
  logic [PW-1:0]       per_wide;
  logic [WW-1:0]       ms_wide;
  logic                per_sat, ms_sat, tok_zero;
  logic [tbrl_pkg::PER_W-1:0] per_fin;
  logic [tbrl_pkg::MS_W-1:0]  ms_fin;
  logic signed [LW-1:0] lvl_wide;
  logic                 lvl_under;
  logic signed [OW-1:0] lvl_fin;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_ms_r  <= tbrl_pkg::RST_FILL_PERIOD;
      tokens_r   <= tbrl_pkg::RST_TOKENS;
      capacity_r <= tbrl_pkg::RST_CAPACITY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tbrl_pkg::CFG_FILL_PERIOD: fill_ms_r  <= cfg_data[tbrl_pkg::FP_W-1:0];
        tbrl_pkg::CFG_TOKENS:      tokens_r   <= cfg_data[tbrl_pkg::TOK_W-1:0];
        tbrl_pkg::CFG_CAPACITY:    capacity_r <= cfg_data[tbrl_pkg::TOK_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign in_stall = (state_r != tbrl_pkg::S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == tbrl_pkg::S_FIN) && out_free;

  assign bkt_ctrl.clamp   = (state_r == tbrl_pkg::S_CLAMP);
  assign bkt_ctrl.apply   = (state_r == tbrl_pkg::S_APPLY);
  assign bkt_ctrl.consume = (cmd_r == tbrl_pkg::CMD_CONSUME);
  assign div_start        = bkt_ctrl.apply && bkt_ctrl.consume && !bkt_stat.fits;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tbrl_pkg::S_IDLE:  if (in_take) state_nxt = tbrl_pkg::S_CLAMP;
      tbrl_pkg::S_CLAMP: state_nxt = tbrl_pkg::S_APPLY;
      tbrl_pkg::S_APPLY: state_nxt = div_start ? tbrl_pkg::S_DIV : tbrl_pkg::S_FIN;
      tbrl_pkg::S_DIV:   if (div_stat.done) state_nxt = tbrl_pkg::S_FIN;
      tbrl_pkg::S_FIN:   if (out_free) state_nxt = tbrl_pkg::S_IDLE;
      default:           state_nxt = tbrl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbrl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r <= in_command;
      req_r <= in_request_bytes;
    end
  end

  tbrl_bucket #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_bucket (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (bkt_ctrl),
    .req        (req_r),
    .tokens     (tokens_r),
    .capacity   (capacity_r),
    .stat       (bkt_stat),
    .level      (level),
    .deficit_m1 (deficit_m1)
  );

  tbrl_sdiv #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (deficit_m1),
    .tokens   (tokens_r),
    .fill_ms  (fill_ms_r),
    .stat     (div_stat),
    .quot     (quot),
    .prod     (prod)
  );

  // periods = quotient + 1, ms = (quotient + 1) * fill period
  assign tok_zero = (tokens_r == '0);
  assign per_wide = PW'(quot) + PW'(1);
  assign ms_wide  = WW'(prod) + WW'(fill_ms_r);
  assign per_sat  = |per_wide[PW-1:tbrl_pkg::PER_W];
  assign ms_sat   = |ms_wide[WW-1:tbrl_pkg::MS_W];

  always_comb begin
    if (bkt_stat.granted) begin
      per_fin = '0;
      ms_fin  = '0;
    end else if (tok_zero) begin
      per_fin = '1;
      ms_fin  = (fill_ms_r == '0) ? '0 : '1;
    end else begin
      per_fin = per_sat ? '1 : per_wide[tbrl_pkg::PER_W-1:0];
      ms_fin  = ms_sat ? '1 : ms_wide[tbrl_pkg::MS_W-1:0];
    end
  end

  // level shown on the port saturates at the field minimum
  assign lvl_wide  = LW'(level);
  assign lvl_under = lvl_wide[LW-1] & ~(&lvl_wide[LW-1:OW-1]);
  assign lvl_fin   = lvl_under ? $signed({1'b1, {(OW-1){1'b0}}}) : lvl_wide[OW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_granted_r <= bkt_stat.granted;
      out_periods_r <= per_fin;
      out_ms_r      <= ms_fin;
      out_level_r   <= lvl_fin;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_wait_periods = out_periods_r;
  assign out_wait_ms      = out_ms_r;
  assign out_token_level  = out_level_r;

  `ASSERT_SAME(a_idle_div_quiet, clk, rst_n, !in_stall, !div_stat.busy && !div_stat.done,
               "divider active while idle")
  `ASSERT_SAME(a_grant_no_wait, clk, rst_n, out_valid_r && out_granted_r,
               out_periods_r == '0 && out_ms_r == '0, "granted beat carries a wait")

endmodule

/* dv/tb_top.sv */
// testbench for token_bucket_rate_limiter: directed table then random phases, each
// result beat checked against a table row or the predictor; depends on tbrl_pkg, rtl
`timescale 1ns / 1ps

module tb_top;
  import tbrl_pkg::*;

  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 53;
  localparam int HOLD_CYCLES = 400;
  localparam int WDOG_LIMIT  = 3000;
  localparam int TAIL_CYCLES = LEVEL_BITS_DEF + 12;
  localparam int PRINT_CAP   = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [PER_W-1:0]     PER_SAT    = {PER_W{1'b1}};
  localparam logic [MS_W-1:0]      MS_SAT     = {MS_W{1'b1}};
  localparam bit [63:0]            MS_CAP     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint LVL_FLOOR = -(longint'(1) <<< (LEVEL_BITS_DEF - 1));
  localparam longint OUT_FLOOR = -(longint'(1) <<< (LVL_OUT_W - 1));

  typedef struct packed {
    logic                 granted;
    logic [PER_W-1:0]     wait_periods;
    logic [MS_W-1:0]      wait_ms;
    logic [LVL_OUT_W-1:0] token_level;
  } verdict_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    cmd_t                  cmd;
    logic [REQ_W-1:0]      req;
    bit                    typed;
    verdict_t              want;
  } step_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_command = 1'b0;
  logic [REQ_W-1:0]            in_request_bytes = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b1;
  logic                        out_granted;
  logic [PER_W-1:0]            out_wait_periods;
  logic [MS_W-1:0]             out_wait_ms;
  logic signed [LVL_OUT_W-1:0] out_token_level;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  // bucket copy kept by the predictor
  logic [FP_W-1:0]  fill_ms;
  logic [TOK_W-1:0] tok_per;
  logic [TOK_W-1:0] cap_lim;
  longint           bkt_level;

  verdict_t  due_q[$];
  step_row_t dir_tab[$];

  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  logic rx_hold = 1'b0;
  int  rx_gap;
  int  quiet_cycles = 0;
  int  err_cnt = 0;
  int  n_items = 0;
  int  n_debt = 0;
  int  n_results = 0;
  int  n_cfg = 0;

  token_bucket_rate_limiter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_request_bytes (in_request_bytes),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted      (out_granted),
    .out_wait_periods (out_wait_periods),
    .out_wait_ms      (out_wait_ms),
    .out_token_level  (out_token_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gap_draw();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic verdict_t bucket_step(cmd_t cmd, logic [REQ_W-1:0] req);
    verdict_t  v;
    bit [63:0] deficit, periods, ms;
    longint    cap_v, req_v, shown;
    cap_v = longint'({32'd0, cap_lim});
    req_v = longint'({32'd0, req});
    v.granted = 1'b1;
    v.wait_periods = '0;
    v.wait_ms = '0;
    if (cmd == CMD_TICK) begin
      bkt_level += longint'({32'd0, tok_per});
      if (bkt_level > cap_v) bkt_level = cap_v;
    end else begin
      if (bkt_level > cap_v) bkt_level = cap_v;
      if (bkt_level >= req_v) begin
        bkt_level -= req_v;
      end else begin
        deficit = req_v - bkt_level;
        v.granted = 1'b0;
        // the wait still follows the full deficit when the level floors out
        if (bkt_level < LVL_FLOOR + req_v) bkt_level = LVL_FLOOR;
        else bkt_level -= req_v;
        if (tok_per == '0) begin
          v.wait_periods = PER_SAT;
          v.wait_ms = (fill_ms == '0) ? '0 : MS_SAT;
        end else begin
          periods = (deficit - 64'd1) / {32'd0, tok_per} + 64'd1;
          v.wait_periods = (periods > {16'd0, PER_SAT}) ? PER_SAT : periods[PER_W-1:0];
          if (fill_ms == '0) ms = '0;
          else if (periods > MS_CAP / {48'd0, fill_ms}) ms = MS_CAP;
          else ms = periods * {48'd0, fill_ms};
          v.wait_ms = ms[MS_W-1:0];
        end
      end
    end
    shown = (bkt_level < OUT_FLOOR) ? OUT_FLOOR : bkt_level;
    v.token_level = shown[LVL_OUT_W-1:0];
    return v;
  endfunction

  function automatic step_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    step_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    r.cmd = CMD_TICK;
    r.req = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic step_row_t item_row(cmd_t cmd, logic [REQ_W-1:0] req);
    step_row_t r;
    r = cfg_row(CFG_FILL_PERIOD, '0);
    r.is_cfg = 1'b0;
    r.cmd = cmd;
    r.req = req;
    return r;
  endfunction

  function automatic step_row_t known_row(cmd_t cmd, logic [REQ_W-1:0] req, logic g,
                                          logic [PER_W-1:0] per, logic [MS_W-1:0] ms,
                                          longint lvl);
    step_row_t r;
    r = item_row(cmd, req);
    r.typed = 1'b1;
    r.want.granted = g;
    r.want.wait_periods = per;
    r.want.wait_ms = ms;
    r.want.token_level = lvl[LVL_OUT_W-1:0];
    return r;
  endfunction

  task automatic log_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_cnt++;
    if (err_cnt <= PRINT_CAP)
      $display("mismatch in %s at result %0d: got 0x%0h, want 0x%0h",
               what, n_results, got, want);
  endtask

  task automatic send_beat(cmd_t cmd, logic [REQ_W-1:0] req, bit typed, verdict_t known);
    int       gap;
    verdict_t v;
    gap = gap_draw();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_request_bytes <= req;
    do @(posedge clk); while (in_stall);
    v = bucket_step(cmd, req);
    if (!v.granted) n_debt++;
    due_q.push_back(typed ? known : v);
    n_items++;
  endtask

  // valid stays up across back-to-back writes, dropped after the last one
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FILL_PERIOD: fill_ms = data[FP_W-1:0];
      CFG_TOKENS:      tok_per = data;
      CFG_CAPACITY:    cap_lim = data;
      default: ;
    endcase
    n_cfg++;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
  endtask

  // result side: random stall per beat, plus the long hold-off
  always @(posedge clk) begin : result_side
    verdict_t w;
    int g;
    if (!rst_n) begin
      out_stall <= 1'b1;
      rx_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (due_q.size() == 0) begin
          log_mismatch("unexpected result beat", 64'd0, 64'd0);
        end else begin
          w = due_q.pop_front();
          if (out_granted !== w.granted)
            log_mismatch("granted", {63'd0, out_granted}, {63'd0, w.granted});
          if (out_wait_periods !== w.wait_periods)
            log_mismatch("wait_periods", {16'd0, out_wait_periods}, {16'd0, w.wait_periods});
          if (out_wait_ms !== w.wait_ms)
            log_mismatch("wait_ms", {1'b0, out_wait_ms}, {1'b0, w.wait_ms});
          if (out_token_level !== w.token_level)
            log_mismatch("token_level", {16'd0, out_token_level}, {16'd0, w.token_level});
        end
        g = gap_draw();
        rx_gap <= g;
        out_stall <= (g != 0) || rx_hold;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= (rx_gap > 1) || rx_hold;
      end else begin
        out_stall <= rx_hold;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results still due",
               WDOG_LIMIT, due_q.size());
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    step_row_t        row;
    cmd_t             cmd;
    logic [REQ_W-1:0] req;
    logic [FP_W-1:0]  fp;
    logic [TOK_W-1:0] tok, cap;
    longint           base, t;

    fill_ms = RST_FILL_PERIOD;
    tok_per = RST_TOKENS;
    cap_lim = RST_CAPACITY;
    bkt_level = longint'({32'd0, RST_CAPACITY});

    dir_tab.push_back(known_row(CMD_TICK, 32'd0, 1'b1, '0, '0, 65536));
    dir_tab.push_back(known_row(CMD_CONSUME, 32'd0, 1'b1, '0, '0, 65536));
    dir_tab.push_back(known_row(CMD_CONSUME, 32'd65536, 1'b1, '0, '0, 0));
    dir_tab.push_back(known_row(CMD_TICK, 32'd0, 1'b1, '0, '0, 1024));
    // capacity drops below the level, clamp shows on the next item
    dir_tab.push_back(cfg_row(CFG_CAPACITY, 32'd1000));
    dir_tab.push_back(known_row(CMD_CONSUME, 32'd0, 1'b1, '0, '0, 1000));
    dir_tab.push_back(known_row(CMD_CONSUME, 32'd1001, 1'b0, 48'd1, 63'd100, -1));
    dir_tab.push_back(known_row(CMD_TICK, 32'hFFFF_FFFF, 1'b1, '0, '0, 1000));
    dir_tab.push_back(known_row(CMD_CONSUME, 32'd3049, 1'b0, 48'd3, 63'd300, -2049));
    dir_tab.push_back(cfg_row(CFG_FILL_PERIOD, 32'd0));
    dir_tab.push_back(known_row(CMD_CONSUME, 32'd1, 1'b0, 48'd3, 63'd0, -2050));
    dir_tab.push_back(cfg_row(CFG_TOKENS, 32'd0));
    dir_tab.push_back(cfg_row(CFG_FILL_PERIOD, 32'd100));
    dir_tab.push_back(known_row(CMD_CONSUME, 32'd5, 1'b0, PER_SAT, MS_SAT, -2055));
    dir_tab.push_back(cfg_row(CFG_FILL_PERIOD, 32'd0));
    dir_tab.push_back(known_row(CMD_CONSUME, 32'd0, 1'b0, PER_SAT, '0, -2055));
    dir_tab.push_back(known_row(CMD_TICK, 32'd0, 1'b1, '0, '0, -2055));
    dir_tab.push_back(cfg_row(CFG_FILL_PERIOD, 32'h0000_FFFF));
    dir_tab.push_back(cfg_row(CFG_TOKENS, 32'hFFFF_FFFF));
    dir_tab.push_back(cfg_row(CFG_CAPACITY, 32'hFFFF_FFFF));
    dir_tab.push_back(item_row(CMD_TICK, 32'd0));
    dir_tab.push_back(known_row(CMD_TICK, 32'd0, 1'b1, '0, '0, 64'h0_FFFF_FFFF));
    dir_tab.push_back(known_row(CMD_CONSUME, 32'hFFFF_FFFF, 1'b1, '0, '0, 0));
    dir_tab.push_back(known_row(CMD_CONSUME, 32'hFFFF_FFFF, 1'b0, 48'd1, 63'd65535,
                                -64'sh0_FFFF_FFFF));
    dir_tab.push_back(item_row(CMD_CONSUME, 32'hFFFF_FFFF));
    dir_tab.push_back(cfg_row(CFG_TOKENS, 32'd1));
    dir_tab.push_back(cfg_row(CFG_FILL_PERIOD, 32'd1));
    dir_tab.push_back(cfg_row(CFG_CAPACITY, 32'd1));
    dir_tab.push_back(item_row(CMD_CONSUME, 32'hFFFF_FFFF));
    dir_tab.push_back(cfg_row(CFG_FILL_PERIOD, 32'h0000_FFFF));
    dir_tab.push_back(item_row(CMD_CONSUME, 32'hFFFF_FFFF));
    dir_tab.push_back(item_row(CMD_TICK, 32'hA5A5_5A5A));
    // write to an index past the register list must change nothing
    dir_tab.push_back(cfg_row(CFG_UNUSED, 32'hFFFF_FFFF));
    dir_tab.push_back(item_row(CMD_CONSUME, 32'd1));
    dir_tab.push_back(cfg_row(CFG_CAPACITY, 32'd0));
    dir_tab.push_back(item_row(CMD_CONSUME, 32'd0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        if (i == 0 || !dir_tab[i-1].is_cfg) settle();
        cfg_write(row.idx, row.data, i + 1 == dir_tab.size() || !dir_tab[i+1].is_cfg);
      end else begin
        send_beat(row.cmd, row.req, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      calm = (ph == 1 || ph == 6);
      case ($urandom_range(0, 7))
        0: fp = '0;
        1: fp = 16'd1;
        2: fp = 16'hFFFF;
        3, 4: fp = FP_W'($urandom_range(1, 1000));
        default: fp = FP_W'($urandom_range(0, 16'hFFFF));
      endcase
      case ($urandom_range(0, 11))
        0: tok = '0;
        1: tok = 32'd1;
        2: tok = 32'hFFFF_FFFF;
        3, 4, 5: tok = $urandom_range(1, 4096);
        default: tok = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0: cap = $urandom_range(0, 1);
        1: cap = 32'hFFFF_FFFF;
        2, 3, 4: cap = $urandom_range(1, 32'h0010_0000);
        default: cap = $urandom;
      endcase
      cfg_write(CFG_FILL_PERIOD, {16'd0, fp}, 1'b0);
      cfg_write(CFG_TOKENS, tok, 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(CFG_CAPACITY, cap, 1'b0);
        cfg_write(CFG_UNUSED, $urandom, 1'b1);
      end else begin
        cfg_write(CFG_CAPACITY, cap, 1'b1);
      end

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == 8) hold_req = 1'b1;
        if (ph == 5 && k == PHASE_ITEMS / 2) settle();
        cmd = ($urandom_range(0, 99) < 35) ? CMD_TICK : CMD_CONSUME;
        base = (bkt_level > longint'({32'd0, cap_lim})) ? longint'({32'd0, cap_lim})
                                                         : bkt_level;
        // requests near the current level land on both sides of the grant boundary
        case ($urandom_range(0, 9))
          0, 1, 2: req = $urandom;
          3, 4: req = $urandom_range(0, tok_per);
          5, 6: begin
            t = base + longint'($urandom_range(0, 2)) - 1;
            req = (base <= 0) ? $urandom_range(0, 3) : t[REQ_W-1:0];
          end
          7: req = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
          default: req = $urandom_range(0, 255);
        endcase
        send_beat(cmd, req, 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d items (%0d ran into debt) and %0d result beats,",
             n_items, n_debt, n_results);
    $display("with %0d register writes over %0d random setups, %0d mismatches",
             n_cfg, PHASES, err_cnt);
    if (err_cnt == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* token_bucket_rate_limiter.f */
+incdir+hw/rtl
hw/rtl/tbrl_pkg.sv
hw/rtl/tbrl_bucket.sv
hw/rtl/tbrl_sdiv.sv
hw/rtl/token_bucket_rate_limiter.sv
dv/tb_top.sv
